### rtl/core/wft_pkg.sv
// Shared types and constants for the weighted frequency moment tracker.
package wft_pkg;

  localparam int POWER_W = 48;
  localparam int COUNT_W = 17;
  localparam int VALUE_W = 16;

  // Command codes
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef struct packed {
    logic               command;
    logic [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [POWER_W-1:0] power;
    logic [COUNT_W-1:0] new_count;
    logic               error;
  } result_t;

  // Registered outcome of the count update, handed to the sum stage
  typedef struct packed {
    logic               vld;
    logic               err;
    logic               sub;
    logic [POWER_W-1:0] delta;
    logic [COUNT_W-1:0] new_count;
  } calc_t;

endpackage

### rtl/core/wft_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module wft_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/wft_calc.sv
// Count update and weighted delta multiply for one item.
module wft_calc #(
  parameter int VALUE_BITS = 16,
  parameter int COUNT_MAX  = 65536
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              valid,
  input  logic                              sub,
  input  logic [VALUE_BITS-1:0]             value,
  input  logic [$clog2(COUNT_MAX+1)-1:0]    count,
  output logic                              we,
  output logic [$clog2(COUNT_MAX+1)-1:0]    wdata,
  output wft_pkg::calc_t                    calc
);

  import wft_pkg::*;

  localparam int CNT_W  = $clog2(COUNT_MAX + 1);
  localparam int PROD_W = CNT_W + 1 + VALUE_BITS;

  logic                          err;
  logic [CNT_W-1:0]              cnt_new;
  logic [CNT_W-1:0]              cnt_base;
  logic [CNT_W:0]                factor;
  logic [PROD_W-1:0]             prod;
  logic [POWER_W+PROD_W-1:0]     prod_ext;
  logic [COUNT_W+CNT_W-1:0]      cnt_ext;
  logic [CNT_W-1:0]              cnt_out;

  // Reject remove of an absent value and add at full count
  assign err     = sub ? (count == '0) : (count >= CNT_W'(COUNT_MAX));
  assign cnt_new = sub ? (count - CNT_W'(1)) : (count + CNT_W'(1));

  // 2c+1 for add, 2(c-1)+1 = 2c-1 for remove
  assign cnt_base = sub ? (count - CNT_W'(1)) : count;
  assign factor   = {cnt_base, 1'b1};
  assign prod     = PROD_W'(factor) * PROD_W'(value);
  assign prod_ext = {{POWER_W{1'b0}}, prod};

  assign cnt_out = err ? count : cnt_new;
  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_out};

  // Table write-back
  assign we    = valid & ~err;
  assign wdata = cnt_new;

  // Stage register toward the sum update
  always_ff @(posedge clk) begin
    if (rst) begin
      calc.vld <= 1'b0;
    end else begin
      calc.vld <= valid;
    end
    calc.err       <= err;
    calc.sub       <= sub;
    calc.delta     <= prod_ext[POWER_W-1:0];
    calc.new_count <= cnt_ext[COUNT_W-1:0];
  end

endmodule

### rtl/core/weighted_frequency_moment_tracker_core.sv
// Top level of the weighted frequency moment tracker.
// Tracks per-value counts in a 2^VALUE_BITS entry table and the running sum of
// count^2 * value (modulo 2^48). After reset the table is cleared by a pass over
// all 2^VALUE_BITS entries (65536 at the defaults) during which busy stays high.
// Then an item is taken when start is high and busy is low; busy is high in
// the cycle after each transfer while the table entry is read and updated,
// so no new item is taken until that update is done. The result appears with
// done for one cycle, via the calc and result registers; the receiver cannot
// stall it. The read-modify-write of one registered-read RAM limits intake.
module weighted_frequency_moment_tracker_core #(
  parameter int VALUE_BITS = 16,
  parameter int COUNT_MAX  = 65536
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  wft_pkg::item_t   item,
  output logic             done,
  output wft_pkg::result_t result
);

  import wft_pkg::*;

  localparam int CNT_W = $clog2(COUNT_MAX + 1);
  localparam int DEPTH = 1 << VALUE_BITS;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_CALC  = 2'd2;

  logic [1:0]              state;
  logic [1:0]              state_next;
  logic [VALUE_BITS-1:0]   clr_addr;
  logic [VALUE_BITS-1:0]   s_value;
  logic                    s_sub;
  logic [VALUE_W+VALUE_BITS-1:0] val_ext;
  logic [VALUE_BITS-1:0]   in_idx;
  logic                    accept;

  logic                    ram_we;
  logic [VALUE_BITS-1:0]   ram_waddr;
  logic [CNT_W-1:0]        ram_wdata;
  logic [CNT_W-1:0]        ram_rdata;
  logic                    upd_we;
  logic [CNT_W-1:0]        upd_wdata;
  calc_t                   calc;

  logic [POWER_W-1:0]      power_sum;
  logic [POWER_W-1:0]      power_next;

  // Only the low VALUE_BITS of the value take part
  assign val_ext = {{VALUE_BITS{1'b0}}, item.value};
  assign in_idx  = val_ext[VALUE_BITS-1:0];

  assign busy   = (state != ST_IDLE);
  assign accept = start & ~busy;

  // Control sequence: clear pass, idle, update
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == '1) state_next = ST_IDLE;
      ST_IDLE:  if (start) state_next = ST_CALC;
      ST_CALC:  state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + VALUE_BITS'(1);
      end
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      s_value <= in_idx;
      s_sub   <= (item.command == CMD_REMOVE);
    end
  end

  // Write port shared by the clear pass and the update
  assign ram_we    = (state == ST_CLEAR) | upd_we;
  assign ram_waddr = (state == ST_CLEAR) ? clr_addr : s_value;
  assign ram_wdata = (state == ST_CLEAR) ? '0 : upd_wdata;

  wft_ram #(
    .WIDTH (CNT_W),
    .DEPTH (DEPTH)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  wft_calc #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_MAX  (COUNT_MAX)
  ) u_calc (
    .clk   (clk),
    .rst   (rst),
    .valid (state == ST_CALC),
    .sub   (s_sub),
    .value (s_value),
    .count (ram_rdata),
    .we    (upd_we),
    .wdata (upd_wdata),
    .calc  (calc)
  );

  // Running sum, wraps modulo 2^48
  always_comb begin
    power_next = power_sum;
    if (calc.vld && !calc.err) begin
      power_next = calc.sub ? (power_sum - calc.delta) : (power_sum + calc.delta);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_sum <= '0;
      done      <= 1'b0;
    end else begin
      power_sum <= power_next;
      done      <= calc.vld;
    end
    if (calc.vld) begin
      result.power     <= power_next;
      result.new_count <= calc.new_count;
      result.error     <= calc.err;
    end
  end

  // Every result is preceded by an update state
  a_done_after_calc: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_CALC, 2))
    else $error("result without a matching update");

  // No two results come back to back
  a_done_spacing: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("back-to-back results");

  // Reported power is the stored sum
  a_power_matches: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.power == power_sum))
    else $error("result power differs from running sum");

  // A rejected remove always reports a zero count
  a_remove_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.error && $past(calc.sub)) |-> (result.new_count == '0))
    else $error("rejected remove with nonzero count");

endmodule

### sim/testbench.sv
// Self-checking testbench for the weighted frequency moment tracker core.
module testbench;
  import wft_pkg::*;

  localparam int COUNT_LIMIT = 65536;
  localparam int TABLE_SIZE  = 1 << VALUE_W;

  logic    clk = 1'b0;
  logic    rst;
  logic    start;
  logic    busy;
  item_t   item;
  logic    done;
  result_t result;

  weighted_frequency_moment_tracker_core uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  always #6 clk = ~clk;

  // Predictor state: per-value histogram and running moment sum
  bit [COUNT_W-1:0] count_tab [TABLE_SIZE];
  bit [POWER_W-1:0] moment_sum;
  result_t          pending_results [$];

  int idle_pct    = 8;
  int n_transfers = 0;
  int n_rejected  = 0;
  int n_wraps     = 0;
  int n_checked   = 0;
  int n_failures  = 0;

  // Directed stimulus row; typed rows carry their expected result
  typedef struct packed {
    logic               cmd;
    logic [VALUE_W-1:0] value;
    logic [19:0]        reps;
    logic               typed;
    logic [POWER_W-1:0] power;
    logic [COUNT_W-1:0] cnt;
    logic               err;
  } plan_row_t;

  plan_row_t plan [20];

  // Apply one add/remove to the predictor and return the expected result
  function automatic result_t apply_update(input item_t it);
    bit [COUNT_W-1:0] c;
    bit [63:0]        delta;
    result_t          r;
    c = count_tab[it.value];
    r.error = 1'b0;
    if (it.command == CMD_REMOVE) begin
      if (c == '0) begin
        r.error = 1'b1;
      end else begin
        delta = (64'(c) * 2 - 1) * 64'(it.value);
        if (delta[POWER_W-1:0] > moment_sum) n_wraps++;
        moment_sum = moment_sum - delta[POWER_W-1:0];
        c = c - COUNT_W'(1);
        count_tab[it.value] = c;
      end
    end else begin
      if (int'(c) >= COUNT_LIMIT) begin
        r.error = 1'b1;
      end else begin
        delta = (64'(c) * 2 + 1) * 64'(it.value);
        if (moment_sum + delta[POWER_W-1:0] < moment_sum) n_wraps++;
        moment_sum = moment_sum + delta[POWER_W-1:0];
        c = c + COUNT_W'(1);
        count_tab[it.value] = c;
      end
    end
    if (r.error) n_rejected++;
    r.power     = moment_sum;
    r.new_count = c;
    return r;
  endfunction

  // Drive one item from a falling edge, wait for its transfer, queue the expectation
  task automatic send_item(input item_t it, input logic typed, input result_t typed_res);
    result_t r;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = apply_update(it);
    pending_results.push_back(typed ? typed_res : r);
    n_transfers++;
    @(negedge clk);
  endtask

  // Result checker: every done cycle is compared with the oldest expectation
  result_t want;
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: power %h new_count %h error %b",
               result.power, result.new_count, result.error);
        n_failures++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (result.power !== want.power) begin
          $error("power mismatch: expected %h, got %h", want.power, result.power);
          n_failures++;
        end
        if (result.new_count !== want.new_count) begin
          $error("new_count mismatch: expected %h, got %h", want.new_count, result.new_count);
          n_failures++;
        end
        if (result.error !== want.error) begin
          $error("error mismatch: expected %b, got %b", want.error, result.error);
          n_failures++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    item_t                  it;
    result_t                tr;
    logic [VALUE_W-1:0]     value_pool [8];
    int                     sel;
    int                     guard;

    start = 1'b0;
    item  = '0;
    rst   = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    plan = '{
      // removes of absent values right after reset
      '{CMD_REMOVE, 16'h0000, 20'd1, 1'b1, 48'h0, 17'h0, 1'b1},
      '{CMD_REMOVE, 16'hFFFF, 20'd1, 1'b1, 48'h0, 17'h0, 1'b1},
      // zero weight leaves the sum alone
      '{CMD_ADD,    16'h0000, 20'd1, 1'b1, 48'h0, 17'h1, 1'b0},
      '{CMD_ADD,    16'h0000, 20'd1, 1'b1, 48'h0, 17'h2, 1'b0},
      // largest value, count 1 then 2 and back
      '{CMD_ADD,    16'hFFFF, 20'd1, 1'b1, 48'h0_FFFF, 17'h1, 1'b0},
      '{CMD_ADD,    16'hFFFF, 20'd1, 1'b1, 48'h3_FFFC, 17'h2, 1'b0},
      '{CMD_REMOVE, 16'hFFFF, 20'd1, 1'b1, 48'h0_FFFF, 17'h1, 1'b0},
      '{CMD_REMOVE, 16'hFFFF, 20'd1, 1'b1, 48'h0, 17'h0, 1'b0},
      // alternating bit patterns, then value 0 removed until absent
      '{CMD_ADD,    16'h5555, 20'd1, 1'b0, 48'h0, 17'h0, 1'b0},
      '{CMD_ADD,    16'hAAAA, 20'd1, 1'b0, 48'h0, 17'h0, 1'b0},
      '{CMD_REMOVE, 16'h5555, 20'd1, 1'b0, 48'h0, 17'h0, 1'b0},
      '{CMD_REMOVE, 16'hAAAA, 20'd1, 1'b1, 48'h0, 17'h0, 1'b0},
      '{CMD_REMOVE, 16'h0000, 20'd2, 1'b0, 48'h0, 17'h0, 1'b0},
      '{CMD_REMOVE, 16'h0000, 20'd1, 1'b1, 48'h0, 17'h0, 1'b1},
      // fill the largest value up to the count ceiling, then one add too many
      '{CMD_ADD,    16'hFFFF, 20'd65536, 1'b0, 48'h0, 17'h0, 1'b0},
      '{CMD_ADD,    16'hFFFF, 20'd1, 1'b1, 48'hFFFF_0000_0000, 17'h10000, 1'b1},
      // push the sum past 2^48 and bring it back
      '{CMD_ADD,    16'h8000, 20'd400, 1'b0, 48'h0, 17'h0, 1'b0},
      '{CMD_REMOVE, 16'h8000, 20'd399, 1'b0, 48'h0, 17'h0, 1'b0},
      '{CMD_REMOVE, 16'h8000, 20'd1, 1'b1, 48'hFFFF_0000_0000, 17'h0, 1'b0},
      '{CMD_REMOVE, 16'h0001, 20'd1, 1'b1, 48'hFFFF_0000_0000, 17'h0, 1'b1}
    };

    // Directed part
    foreach (plan[i]) begin
      it.command   = plan[i].cmd;
      it.value     = plan[i].value;
      tr.power     = plan[i].power;
      tr.new_count = plan[i].cnt;
      tr.error     = plan[i].err;
      for (int n = 0; n < int'(plan[i].reps); n++)
        send_item(it, plan[i].typed, tr);
    end

    // Random part: mostly a small set of values so removes find something to take
    foreach (value_pool[i]) value_pool[i] = VALUE_W'($urandom);
    for (int k = 0; k < 1000; k++) begin
      idle_pct = (k >= 400 && k < 600) ? 0 : 8;
      sel = $urandom_range(99);
      if (sel < 70) begin
        it.value = value_pool[$urandom_range(7)];
      end else if (sel < 90) begin
        it.value = VALUE_W'($urandom);
      end else begin
        case ($urandom_range(2))
          0: it.value = '0;
          1: it.value = '1;
          default: it.value = 16'h8000;
        endcase
      end
      it.command = ($urandom_range(99) < 55) ? CMD_ADD : CMD_REMOVE;
      send_item(it, 1'b0, '0);
    end
    start <= 1'b0;

    // Drain outstanding results, then wait on for stray strobes
    guard = 0;
    while (pending_results.size() != 0 && guard < 100) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      n_failures++;
    end

    $display("Run covered %0d transfers, %0d of them rejected, with %0d wraps of the sum.",
             n_transfers, n_rejected, n_wraps);
    $display("Results checked: %0d, failures: %0d.", n_checked, n_failures);
    if (n_failures == 0) begin
      $display("weighted_frequency_moment_tracker_core test passed");
    end else begin
      $display("weighted_frequency_moment_tracker_core test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #12_000_000;
    $display("weighted_frequency_moment_tracker_core test failed");
    $finish;
  end

endmodule
